### hw/rtl/spli_pkg.sv
package spli_pkg;

  localparam int BYTES_PER_WORD = 4;
  localparam int FRAME_BITS     = 9;
  localparam int BYTE_BITS      = 8;
  localparam int TX_W           = BYTES_PER_WORD * BYTE_BITS;
  localparam int BYTE_CW        = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
  localparam int FRAME_CW       = $clog2(FRAME_BITS + 1);

  typedef enum logic [1:0] {
    FUNC_RX_BIT = 2'd0,
    FUNC_RX_END = 2'd1,
    FUNC_SEND   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic KIND_TX_BIT = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic        rx_bit;
    logic [31:0] tx_word;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic        tx_bit;
    logic [31:0] rx_word;
    logic        rx_failed;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic        line_bit;
    logic        last;
  } tx_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic        failed;
  } rx_stat_t;

endpackage

### hw/rtl/spli_rx.sv
module spli_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [1:0]        func,
  input  logic              rx_bit,
  output spli_pkg::rx_stat_t stat
);
  import spli_pkg::*;

  logic [31:0]         word_r, word_nxt;
  logic [FRAME_CW-1:0] cnt_r, cnt_nxt;
  logic                par_r, par_nxt;
  logic                fail_r, fail_nxt;
  logic [FRAME_CW-1:0] cnt_inc;
  logic                par_inc;

  assign cnt_inc = cnt_r + FRAME_CW'(1);
  assign par_inc = par_r ^ rx_bit;

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    par_nxt  = par_r;
    fail_nxt = fail_r;
    if (take) begin
      case (func)
        FUNC_RX_BIT: begin
          if (!fail_r) begin
            if (cnt_inc == FRAME_CW'(FRAME_BITS)) begin
              // parity bit closes the frame
              if (par_inc) begin
                fail_nxt = 1'b1;
                word_nxt = '0;
              end
              par_nxt = 1'b0;
              cnt_nxt = '0;
            end else begin
              par_nxt  = par_inc;
              cnt_nxt  = cnt_inc;
              word_nxt = {word_r[30:0], rx_bit};
            end
          end
        end
        FUNC_RX_END: begin
          cnt_nxt  = '0;
          par_nxt  = 1'b0;
          fail_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      cnt_r  <= '0;
      par_r  <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
      par_r  <= par_nxt;
      fail_r <= fail_nxt;
    end
  end

  assign stat.word   = word_r;
  assign stat.failed = fail_r;

endmodule

### hw/rtl/spli_tx.sv
module spli_tx (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [31:0]         word,
  input  logic                adv,
  output logic                busy,
  output spli_pkg::tx_beat_t  beat
);
  import spli_pkg::*;

  logic [TX_W-1:0]     shift_r;
  logic [BYTE_CW-1:0]  byte_r;
  logic [FRAME_CW-1:0] bit_r;
  logic                busy_r;
  logic [7:0]          cur_byte;
  logic                par_slot;
  logic                last_beat;

  assign cur_byte  = shift_r[TX_W-1 -: BYTE_BITS];
  assign par_slot  = (bit_r == FRAME_CW'(FRAME_BITS - 1));
  assign last_beat = par_slot && (byte_r == BYTE_CW'(BYTES_PER_WORD - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      byte_r <= '0;
      bit_r  <= '0;
    end else if (load) begin
      busy_r  <= 1'b1;
      byte_r  <= '0;
      bit_r   <= '0;
      shift_r <= TX_W'(word);
    end else if (busy_r && adv) begin
      if (par_slot) begin
        // advance to the next byte
        bit_r   <= '0;
        byte_r  <= byte_r + BYTE_CW'(1);
        shift_r <= shift_r << BYTE_BITS;
        if (last_beat) busy_r <= 1'b0;
      end else begin
        bit_r <= bit_r + FRAME_CW'(1);
      end
    end
  end

  assign busy          = busy_r;
  assign beat.valid    = busy_r;
  assign beat.last     = last_beat;
  assign beat.line_bit = par_slot ? (^cur_byte) : cur_byte[3'd7 - bit_r[2:0]];

endmodule

### hw/rtl/serial_parity_link_interface.sv
// Serial link interface with even parity, one line bit per beat.
//
// Input channel (in_valid / in_stall / in_data): each beat carries a func
// code. A received bit sample updates the receive frame state and gives no
// result. An end-of-reception beat gives one report beat with the received
// word and the failure flag. A send beat gives 9 * BYTES_PER_WORD line-bit
// beats (36 by default), bytes MSB first, each byte followed by its
// even-parity bit; the final one has last set. Code 3 is dropped.
//
// Output channel (out_valid / out_stall / out_data) is fed from a result
// register. A report passes through the input and result registers; a send
// goes via the input register and serializer to the result register.
// Throughput: one input beat per cycle for samples and reports unless input
// stalls; a send occupies the serializer until its last line bit is taken,
// while the input register holds the next beat.
//
// Reset (rst_n low, synchronous) clears the receive word, frame count,
// parity and failure flag, and empties the input and result registers.
// While the receiver stalls, the result beat holds and bit samples drain
// if the serializer is idle; a held report or busy serializer stalls input.
module serial_parity_link_interface (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  spli_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output spli_pkg::out_t out_data
);
  import spli_pkg::*;

  in_t      in_r;
  logic     in_valid_r;
  out_t     out_r;
  logic     out_valid_r;
  logic     out_open;
  logic     consume;
  logic     tx_busy;
  logic     tx_load;
  tx_beat_t tx_beat;
  rx_stat_t rx_stat;

  // Result register can take a new beat when empty or being drained.
  assign out_open = !out_valid_r || !out_stall;

  // Consume the held beat unless the serializer is busy or a report has
  // nowhere to go.
  assign consume  = in_valid_r && !tx_busy &&
                    ((in_r.func != FUNC_RX_END) || out_open);
  assign in_stall = in_valid_r && !consume;
  assign tx_load  = consume && (in_r.func == FUNC_SEND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
      in_r       <= in_data;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  spli_rx u_rx (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (consume),
    .func   (in_r.func),
    .rx_bit (in_r.rx_bit),
    .stat   (rx_stat)
  );

  spli_tx u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (tx_load),
    .word  (in_r.tx_word),
    .adv   (out_open),
    .busy  (tx_busy),
    .beat  (tx_beat)
  );

  // Load the result register: serializer beats first, then reports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      if (tx_beat.valid) begin
        out_valid_r     <= 1'b1;
        out_r.kind      <= KIND_TX_BIT;
        out_r.tx_bit    <= tx_beat.line_bit;
        out_r.rx_word   <= '0;
        out_r.rx_failed <= 1'b0;
        out_r.last      <= tx_beat.last;
      end else if (consume && (in_r.func == FUNC_RX_END)) begin
        out_valid_r     <= 1'b1;
        out_r.kind      <= KIND_REPORT;
        out_r.tx_bit    <= 1'b0;
        out_r.rx_word   <= rx_stat.word;
        out_r.rx_failed <= rx_stat.failed;
        out_r.last      <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/spli_checker.sv
module spli_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input spli_pkg::out_t out_data
);
  import spli_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_REPORT) |-> out_data.last && !out_data.tx_bit)
    else $error("report beat malformed");

  a_tx_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_TX_BIT) |->
      (out_data.rx_word == 32'd0) && !out_data.rx_failed)
    else $error("line bit beat carries receive fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("registers not empty after reset");

endmodule

bind serial_parity_link_interface spli_checker u_spli_checker (.*);
